### hdl/particle_euler_step_macros.svh
// assertion macros for the particle integrator
`ifndef PARTICLE_EULER_STEP_MACROS_SVH
`define PARTICLE_EULER_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define PES_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PES_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PES_ASSERT(label, clk, rst_n, prop, msg)
`define PES_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### hdl/pes_pkg.sv
// shared types and constants for the particle integrator
package pes_pkg;
	typedef enum logic [1:0] {
		OP_SPAWN = 2'd0,
		OP_FORCE = 2'd1,
		OP_UPDATE = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_VEL,
		ST_POS,
		ST_LIFE,
		ST_RAD,
		ST_OUT
	} state_t;

	localparam int REG_W = 31;
	localparam logic [REG_W-1:0] ONE_Q = 31'd65536;
	localparam logic [30:0] DT_MAX = 31'd6554;
	localparam logic [30:0] OUT_MAX = 31'h7fffffff;
	localparam logic [0:0] CFG_MASS = 1'b0;
	localparam logic [0:0] CFG_DECAY = 1'b1;

	typedef struct packed {
		logic div_start;
		logic vel_en;
		logic pos_en;
	} lane_ctl_t;
endpackage

### hdl/pes_lane.sv
// one axis lane: divider for force/mass and the euler multiply-accumulate
module pes_lane #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pes_pkg::lane_ctl_t            ctl,
	input  logic                          spawn,
	input  logic                          zero_acc,
	input  logic signed [31:0]            pos_in,
	input  logic signed [31:0]            vel_in,
	input  logic signed [31:0]            force_in,
	input  logic [30:0]                   mass,
	input  logic [12:0]                   dt,
	output logic                          div_busy,
	output logic signed [COORD_WIDTH-1:0] pos,
	output logic signed [COORD_WIDTH-1:0] vel
);
	localparam int CW = COORD_WIDTH;
	localparam int NW = 48;
	localparam int PW = CW + 14;
	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [5:0] DIV_STEPS = 6'd49;

	logic signed [CW-1:0] pos_q, vel_q, acc_q;
	logic [NW-1:0] num_q;
	logic [31:0] rem_q;
	logic neg_q;
	logic [5:0] cnt_q;
	logic [32:0] trial;
	logic [NW-1:0] quo_mag;
	logic signed [NW:0] quo_s;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] term;
	logic signed [CW+1:0] sum;
	logic signed [CW-1:0] src, base, sat_sum, quo_sat;
	logic [31:0] fmag;

	function automatic logic signed [CW-1:0] sx32(input logic signed [31:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		if (CW >= 32) return CW'(w);
		if (w > 64'(CMAX)) return CMAX;
		if (w < 64'(CMIN)) return CMIN;
		return CW'(w);
	endfunction

	assign fmag = force_in[31] ? 32'(-force_in) : 32'(force_in);
	assign trial = {rem_q, num_q[NW-1]} - {2'b0, mass};
	assign quo_mag = num_q;
	assign quo_s = neg_q ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});
	always_comb begin
		if (CW > NW) quo_sat = CW'(quo_s);
		else if (quo_s > (NW+1)'(CMAX)) quo_sat = CMAX;
		else if (quo_s < (NW+1)'(CMIN)) quo_sat = CMIN;
		else quo_sat = CW'(quo_s);
	end

	// product of one value and dt, truncated toward zero
	assign src = ctl.vel_en ? acc_q : vel_q;
	assign base = ctl.vel_en ? vel_q : pos_q;
	assign prod = PW'(src) * $signed({1'b0, dt});
	assign term = (prod < 0) ? -((-prod) >>> 16) : (prod >>> 16);
	assign sum = (CW+2)'(base) + (CW+2)'(term);
	always_comb begin
		if (sum > (CW+2)'(CMAX)) sat_sum = CMAX;
		else if (sum < (CW+2)'(CMIN)) sat_sum = CMIN;
		else sat_sum = CW'(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			vel_q <= '0;
			acc_q <= '0;
			cnt_q <= '0;
		end else begin
			if (spawn) begin
				pos_q <= sx32(pos_in);
				vel_q <= sx32(vel_in);
				acc_q <= sx32(force_in);
			end else if (ctl.vel_en) begin
				vel_q <= sat_sum;
			end else if (ctl.pos_en) begin
				pos_q <= sat_sum;
				if (zero_acc) acc_q <= '0;
			end
			if (ctl.div_start) begin
				cnt_q <= DIV_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) acc_q <= quo_sat;
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			num_q <= {fmag, 16'b0};
			rem_q <= '0;
			neg_q <= force_in[31];
		end else if (cnt_q > 6'd1) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], num_q[NW-1]};
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end

	assign div_busy = cnt_q != '0;
	assign pos = pos_q;
	assign vel = vel_q;
endmodule

### hdl/pes_merge.sv
// life, radius and output merge of the three lanes
module pes_merge #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          spawn,
	input  logic                          life_en,
	input  logic                          rad_en,
	input  logic [30:0]                   life_in,
	input  logic [30:0]                   mass,
	input  logic [30:0]                   decay_rate,
	input  logic [12:0]                   dt,
	input  logic signed [COORD_WIDTH-1:0] p0,
	input  logic signed [COORD_WIDTH-1:0] p1,
	input  logic signed [COORD_WIDTH-1:0] p2,
	output logic                          alive,
	output logic [30:0]                   radius,
	output logic [95:0]                   pos_word
);
	logic [30:0] rem_q, full_q, rad_q;
	logic [43:0] loss_w;
	logic [30:0] loss;
	logic [30:0] meff;
	logic [33:0] size;
	logic [30:0] age;
	logic [64:0] ramp_prod;
	logic [30:0] ramp_val;
	logic [33:0] r;

	function automatic logic [31:0] clip32(input logic signed [COORD_WIDTH-1:0] v);
		logic signed [COORD_WIDTH+33:0] w;
		w = (COORD_WIDTH+34)'(v);
		if (w > (COORD_WIDTH+34)'(33'sh07fffffff)) return 32'h7fffffff;
		if (w < -(COORD_WIDTH+34)'(33'sh080000000)) return 32'h80000000;
		return 32'(w);
	endfunction

	assign loss_w = decay_rate * dt;
	assign loss = loss_w[43:16] > 28'(0) ? 31'(loss_w[43:16]) : 31'd0;
	assign meff = (mass == '0) ? pes_pkg::ONE_Q : mass;
	assign size = 34'(meff) * 34'd5;
	assign age = full_q - rem_q;
	always_comb begin
		ramp_val = (age < 31'd131072) ? age : rem_q;
		ramp_prod = 65'(ramp_val) * 65'(size);
		if (decay_rate == '0) r = size;
		else if (age < 31'd131072) r = 34'(ramp_prod >> 17);
		else if ($signed({1'b0, age}) > $signed({1'b0, full_q}) - 33'sd131072)
			r = 34'(ramp_prod >> 17);
		else r = size;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			full_q <= '0;
			rad_q <= '0;
		end else begin
			if (spawn) begin
				rem_q <= life_in;
				full_q <= life_in;
			end else if (life_en && rem_q != '0) begin
				rem_q <= (loss >= rem_q) ? '0 : rem_q - loss;
			end
			if (rad_en) begin
				if (rem_q == '0) rad_q <= '0;
				else rad_q <= (r > 34'(pes_pkg::OUT_MAX)) ? pes_pkg::OUT_MAX : 31'(r);
			end
		end
	end

	assign alive = rem_q != '0;
	assign radius = rad_q;
	assign pos_word = {clip32(p2), clip32(p1), clip32(p0)};
endmodule

### hdl/particle_euler_step.sv
// top level of the particle integrator
// spawn, query and dead update pass ST_DIV, ST_RAD and ST_OUT; a live update also passes ST_VEL, ST_POS, ST_LIFE
// throughput: one item at a time, next item taken in the cycle after the result is registered
// apply force waits in ST_DIV for the 48-step serial divider, output stalls hold the item in ST_OUT
// reset clears the particle state to zero, mass and decay_rate to 1.0
`include "particle_euler_step_macros.svh"
module particle_euler_step #(
	parameter int COORD_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, force_x, force_y, force_z, dt, life
	input  logic [351:0] s_axis_tdata,
	// opcode
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_pos_x, out_pos_y, out_pos_z, radius
	output logic [127:0] m_axis_tdata,
	// alive
	output logic         m_axis_tuser,
	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic [30:0]  cfg_data
);
	pes_pkg::state_t state_q, state_d;
	pes_pkg::lane_ctl_t ctl;
	logic [1:0] op_q;
	logic [351:0] data_q;
	logic [30:0] mass_q, decay_q;
	logic [12:0] dt_c;
	logic [2:0] busy;
	logic spawn, life_en, rad_en, accept;
	logic signed [COORD_WIDTH-1:0] p [3];
	logic signed [COORD_WIDTH-1:0] v [3];
	logic alive;
	logic [30:0] radius;
	logic [95:0] pos_word;
	logic out_v_q;
	logic [127:0] out_d_q;
	logic out_u_q;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign dt_c = (data_q[318:288] > pes_pkg::DT_MAX) ? 13'(pes_pkg::DT_MAX)
		: data_q[300:288];

	always_comb begin
		state_d = state_q;
		case (state_q)
			pes_pkg::ST_IDLE: if (accept) state_d = pes_pkg::ST_DIV;
			pes_pkg::ST_DIV: begin
				case (pes_pkg::op_t'(op_q))
					pes_pkg::OP_FORCE: if (busy == 3'b0 && !ctl.div_start) state_d = pes_pkg::ST_RAD;
					pes_pkg::OP_UPDATE: state_d = alive ? pes_pkg::ST_VEL : pes_pkg::ST_RAD;
					default: state_d = pes_pkg::ST_RAD;
				endcase
			end
			pes_pkg::ST_VEL: state_d = pes_pkg::ST_POS;
			pes_pkg::ST_POS: state_d = pes_pkg::ST_LIFE;
			pes_pkg::ST_LIFE: state_d = pes_pkg::ST_RAD;
			pes_pkg::ST_RAD: state_d = pes_pkg::ST_OUT;
			pes_pkg::ST_OUT: if (!out_v_q || m_axis_tready) state_d = pes_pkg::ST_IDLE;
			default: state_d = pes_pkg::ST_IDLE;
		endcase
	end

	logic div_started_q;
	always_comb begin
		ctl = '0;
		spawn = 1'b0;
		life_en = 1'b0;
		rad_en = 1'b0;
		case (state_q)
			pes_pkg::ST_DIV: begin
				spawn = op_q == pes_pkg::OP_SPAWN;
				ctl.div_start = op_q == pes_pkg::OP_FORCE && !div_started_q;
			end
			pes_pkg::ST_VEL: ctl.vel_en = 1'b1;
			pes_pkg::ST_POS: ctl.pos_en = 1'b1;
			pes_pkg::ST_LIFE: life_en = 1'b1;
			pes_pkg::ST_RAD: rad_en = 1'b1;
			default: ;
		endcase
	end

	assign s_axis_tready = state_q == pes_pkg::ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pes_pkg::ST_IDLE;
			mass_q <= pes_pkg::ONE_Q;
			decay_q <= pes_pkg::ONE_Q;
			out_v_q <= 1'b0;
			div_started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			div_started_q <= state_q == pes_pkg::ST_DIV;
			if (cfg_we) begin
				if (cfg_addr == pes_pkg::CFG_MASS) mass_q <= cfg_data;
				else decay_q <= cfg_data;
			end
			if (m_axis_tready) out_v_q <= 1'b0;
			if (state_q == pes_pkg::ST_OUT && (!out_v_q || m_axis_tready)) out_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= s_axis_tdata;
			op_q <= s_axis_tuser;
		end
		if (state_q == pes_pkg::ST_OUT && (!out_v_q || m_axis_tready)) begin
			out_d_q <= {1'b0, radius, pos_word};
			out_u_q <= alive;
		end
	end

	logic [30:0] meff;
	assign meff = (mass_q == '0) ? pes_pkg::ONE_Q : mass_q;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		pes_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .spawn(spawn),
			.zero_acc(1'b1),
			.pos_in(data_q[32*i +: 32]), .vel_in(data_q[96+32*i +: 32]),
			.force_in(data_q[192+32*i +: 32]), .mass(meff), .dt(dt_c),
			.div_busy(busy[i]), .pos(p[i]), .vel(v[i])
		);
	end

	pes_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
		.clk(clk), .arst_n(arst_n), .spawn(spawn), .life_en(life_en), .rad_en(rad_en),
		.life_in(data_q[349:319]), .mass(mass_q), .decay_rate(decay_q), .dt(dt_c),
		.p0(p[0]), .p1(p[1]), .p2(p[2]),
		.alive(alive), .radius(radius), .pos_word(pos_word)
	);

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_d_q;
	assign m_axis_tuser = out_u_q;

	logic unused_v;
	assign unused_v = ^{v[0], v[1], v[2]};

	`PES_ASSERT(a_ready_idle, clk, arst_n, accept |=> !s_axis_tready, "ready while busy")
	`PES_ASSERT(a_lanes_sync, clk, arst_n, busy[0] == busy[1] && busy[1] == busy[2], "lanes out of step")
	`PES_ASSERT(a_div_only_force, clk, arst_n, busy[0] |-> op_q == pes_pkg::OP_FORCE, "divider on wrong op")
endmodule
